### rtl/lcd_pkg.sv
// ----------------------------------------------------------------------------
// lcd_pkg: shared types and constants of the LRU tile directory
// Payload structs, controller state encoding and the controller/datapath link.
// ----------------------------------------------------------------------------
package lcd_pkg;

  localparam int unsigned NumSlots = 512;
  localparam int unsigned SlotW    = $clog2(NumSlots);
  localparam int unsigned CountW   = $clog2(NumSlots + 1);
  localparam int unsigned LenW     = 26;
  localparam int unsigned StampW   = 32;
  localparam int unsigned KeyW     = 64;
  // Entry word: lat(32) lon(32) has_bytes(1) len(26)
  localparam int unsigned EntryW   = KeyW + 1 + LenW;
  localparam logic [LenW-1:0] BudgetReset = LenW'(2097152);

  typedef struct packed {
    logic signed [30:0] lat_key;
    logic signed [31:0] lon_key;
    logic               store_has_tile;
    logic               store_read_ok;
    logic [LenW-1:0]    store_tile_len;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic              present;
    logic              cached;
    logic [8:0]        slot;
    logic [LenW-1:0]   tile_len;
    logic [31:0]       hit_count;
    logic [31:0]       miss_count;
    logic [LenW-1:0]   bytes_used;
    logic [9:0]        entry_count;
  } rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StLook,     // walk slots: match key, track free and LRU candidates
    StLookEnd,  // drain read pipeline
    StDecide,
    StEvict,    // write victim invalid
    StInstall,
    StHitUpd,
    StDone
  } state_e;

  // scan modes for the datapath
  typedef enum logic [1:0] {
    ScanKey,
    ScanAny,
    ScanBytes
  } scan_e;

  typedef struct packed {
    logic   load;       // capture request
    logic   scan_start; // clear scan trackers, reset address
    logic   scan_step;  // issue read of next slot
    scan_e  mode;
    logic   evict;      // invalidate chosen victim
    logic   install;    // write new entry to free slot
    logic   hit_upd;    // refresh stamp of hit slot
    logic   emit;       // drive result strobe
    logic   miss_cnt;
  } cmd_t;

  typedef struct packed {
    logic scan_last;   // final address issued
    logic scan_idle;   // no read in flight
    logic found;
    logic have_victim;
    logic have_bvictim;
    logic full;
    logic want_neg;
    logic want_bytes;
    logic over_budget;
  } sts_t;

endpackage

### rtl/lcd_ram.sv
// ----------------------------------------------------------------------------
// lcd_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module lcd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### rtl/lcd_ctrl.sv
// ----------------------------------------------------------------------------
// lcd_ctrl: access sequencer
// Runs key lookup, hit update, eviction scans and install for one access.
// ----------------------------------------------------------------------------
module lcd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lcd_pkg::sts_t sts_i,
  output lcd_pkg::cmd_t cmd_o
);
  import lcd_pkg::*;

  state_e state_q, state_d;
  scan_e  mode_q, mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mode_q  <= ScanKey;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cmd_o   = '0;
    cmd_o.mode = mode_q;
    busy    = (state_q != StIdle);
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load       = 1'b1;
          cmd_o.scan_start = 1'b1;
          cmd_o.mode       = ScanKey;
          mode_d           = ScanKey;
          state_d          = StLook;
        end
      end
      StLook: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = StLookEnd;
      end
      StLookEnd: begin
        if (sts_i.scan_idle) state_d = StDecide;
      end
      StDecide: begin
        if (mode_q == ScanKey && sts_i.found) begin
          state_d = StHitUpd;
        end else begin
          if (mode_q == ScanKey) cmd_o.miss_cnt = 1'b1;
          if (!sts_i.want_neg && !sts_i.want_bytes) begin
            state_d = StDone;
          end else if (sts_i.full) begin
            // victim scan over all entries; key scan already tracked one
            state_d = (mode_q == ScanBytes) ? StDone : StEvict;
          end else if (sts_i.want_bytes && sts_i.over_budget) begin
            if (mode_q == ScanBytes) begin
              state_d = (sts_i.have_bvictim || sts_i.have_victim) ? StEvict : StInstall;
            end else begin
              cmd_o.scan_start = 1'b1;
              cmd_o.mode       = ScanBytes;
              mode_d           = ScanBytes;
              state_d          = StLook;
            end
          end else begin
            state_d = StInstall;
          end
        end
      end
      StEvict: begin
        cmd_o.evict = 1'b1;
        // re-evaluate with a fresh full scan
        cmd_o.scan_start = 1'b1;
        cmd_o.mode       = ScanBytes;
        mode_d           = ScanBytes;
        state_d          = StLook;
      end
      StInstall: begin
        cmd_o.install = 1'b1;
        state_d       = StDone;
      end
      StHitUpd: begin
        cmd_o.hit_upd = 1'b1;
        state_d       = StDone;
      end
      StDone: begin
        cmd_o.emit = 1'b1;
        state_d    = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

### rtl/lcd_dpath.sv
// ----------------------------------------------------------------------------
// lcd_dpath: directory storage, slot scanner and counters
// Entry RAM, stamp RAM, per-slot valid bits, running totals.
// ----------------------------------------------------------------------------
module lcd_dpath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lcd_pkg::req_t            req_i,
  input  logic                     budget_we,
  input  logic [lcd_pkg::LenW-1:0] budget_wdata,
  input  lcd_pkg::cmd_t            cmd_i,
  output lcd_pkg::sts_t            sts_o,
  output logic                     rsp_valid,
  output lcd_pkg::rsp_t            rsp_o
);
  import lcd_pkg::*;

  logic [LenW-1:0]   budget_q;
  logic [31:0]       lat_q, lon_q;
  logic              has_q, rok_q;
  logic [LenW-1:0]   len_q;
  logic [NumSlots-1:0] valid_q;
  logic [StampW-1:0] clock_q;
  logic [CountW-1:0] count_q;
  logic [LenW-1:0]   held_q;
  logic [31:0]       hits_q, misses_q;

  // scan
  logic [CountW-1:0] addr_q;
  logic              rd_vld_q;
  logic [SlotW-1:0]  rd_slot_q;
  logic              found_q;
  logic [SlotW-1:0]  fslot_q;
  logic              free_q;
  logic [SlotW-1:0]  free_slot_q;
  logic              vic_q, bvic_q;
  logic [SlotW-1:0]  vic_slot_q, bvic_slot_q;
  logic [StampW-1:0] vic_st_q, bvic_st_q;
  logic [LenW-1:0]   vic_len_q, bvic_len_q;
  logic              vic_hb_q, bvic_hb_q;
  logic              hit_hb_q;
  logic [LenW-1:0]   hit_len_q;
  // result
  logic              r_hit_q, r_cached_q, r_present_q;
  logic [SlotW-1:0]  r_slot_q;
  logic [LenW-1:0]   r_len_q;
  logic              rsp_valid_q;

  logic              ent_we, st_we;
  logic [SlotW-1:0]  ram_addr;
  logic [EntryW-1:0] ent_wdata, ent_rdata;
  logic [StampW-1:0] st_wdata, st_rdata;
  logic              install_bytes, want_neg;
  logic [LenW:0]     need;
  logic              use_bvic;
  logic [SlotW-1:0]  ev_slot;
  logic              ev_hb;
  logic [LenW-1:0]   ev_len;
  logic [31:0]       e_lat, e_lon;
  logic              e_hb;
  logic [LenW-1:0]   e_len;

  assign install_bytes = has_q && rok_q && (len_q != '0) && (len_q < budget_q);
  assign want_neg      = !has_q;
  assign need          = {1'b0, held_q} + {1'b0, len_q};
  assign use_bvic      = bvic_q;
  assign ev_slot       = use_bvic ? bvic_slot_q : vic_slot_q;
  assign ev_hb         = use_bvic ? bvic_hb_q : vic_hb_q;
  assign ev_len        = use_bvic ? bvic_len_q : vic_len_q;

  assign {e_lat, e_lon, e_hb, e_len} = ent_rdata;

  always_comb begin
    ent_we    = 1'b0;
    st_we     = 1'b0;
    ram_addr  = addr_q[SlotW-1:0];
    ent_wdata = {lat_q, lon_q, install_bytes, install_bytes ? len_q : LenW'(0)};
    st_wdata  = clock_q + 32'd1;
    if (cmd_i.install) begin
      ent_we   = 1'b1;
      st_we    = 1'b1;
      ram_addr = free_slot_q;
    end else if (cmd_i.hit_upd) begin
      st_we    = 1'b1;
      ram_addr = fslot_q;
    end
  end

  lcd_ram #(.Width(EntryW), .Depth(NumSlots)) u_ent (
    .clk_i, .we_i(ent_we), .addr_i(ram_addr), .wdata_i(ent_wdata), .rdata_o(ent_rdata)
  );
  lcd_ram #(.Width(StampW), .Depth(NumSlots)) u_stamp (
    .clk_i, .we_i(st_we), .addr_i(ram_addr), .wdata_i(st_wdata), .rdata_o(st_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q    <= BudgetReset;
      valid_q     <= '0;
      clock_q     <= '0;
      count_q     <= '0;
      held_q      <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (budget_we) budget_q <= budget_wdata;
      rsp_valid_q <= cmd_i.emit;
      rd_vld_q    <= cmd_i.scan_step;
      if (cmd_i.scan_start) addr_q <= '0;
      else if (cmd_i.scan_step) addr_q <= addr_q + 1'b1;
      if (cmd_i.miss_cnt) misses_q <= misses_q + 32'd1;
      if (cmd_i.hit_upd) begin
        hits_q  <= hits_q + 32'd1;
        clock_q <= clock_q + 32'd1;
      end
      if (cmd_i.evict) begin
        valid_q[ev_slot] <= 1'b0;
        count_q <= count_q - 1'b1;
        if (ev_hb) held_q <= held_q - ev_len;
      end
      if (cmd_i.install) begin
        valid_q[free_slot_q] <= 1'b1;
        count_q <= count_q + 1'b1;
        clock_q <= clock_q + 32'd1;
        if (install_bytes) held_q <= held_q + len_q;
      end
    end
  end

  // scan trackers, request capture and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lat_q <= {req_i.lat_key[30], req_i.lat_key};
      lon_q <= req_i.lon_key;
      has_q <= req_i.store_has_tile;
      rok_q <= req_i.store_read_ok;
      len_q <= req_i.store_tile_len;
    end
    rd_slot_q <= addr_q[SlotW-1:0];
    if (cmd_i.scan_start) begin
      found_q <= 1'b0;
      free_q  <= 1'b0;
      vic_q   <= 1'b0;
      bvic_q  <= 1'b0;
    end else if (rd_vld_q) begin
      if (!valid_q[rd_slot_q]) begin
        if (!free_q) begin
          free_q      <= 1'b1;
          free_slot_q <= rd_slot_q;
        end
      end else begin
        if (cmd_i.mode == ScanKey && !found_q && e_lat == lat_q && e_lon == lon_q) begin
          found_q   <= 1'b1;
          fslot_q   <= rd_slot_q;
          hit_hb_q  <= e_hb;
          hit_len_q <= e_len;
        end
        if (!vic_q || st_rdata < vic_st_q) begin
          vic_q      <= 1'b1;
          vic_slot_q <= rd_slot_q;
          vic_st_q   <= st_rdata;
          vic_hb_q   <= e_hb;
          vic_len_q  <= e_len;
        end
        if (cmd_i.mode == ScanBytes && e_hb && (!bvic_q || st_rdata < bvic_st_q)) begin
          bvic_q      <= 1'b1;
          bvic_slot_q <= rd_slot_q;
          bvic_st_q   <= st_rdata;
          bvic_hb_q   <= e_hb;
          bvic_len_q  <= e_len;
        end
      end
    end
    if (cmd_i.hit_upd) begin
      r_hit_q     <= 1'b1;
      r_cached_q  <= 1'b1;
      r_present_q <= hit_hb_q;
      r_slot_q    <= fslot_q;
      r_len_q     <= hit_len_q;
    end else if (cmd_i.load) begin
      r_hit_q     <= 1'b0;
      r_cached_q  <= 1'b0;
      r_present_q <= 1'b0;
      r_slot_q    <= '0;
      r_len_q     <= '0;
    end else if (cmd_i.install) begin
      r_cached_q  <= 1'b1;
      r_present_q <= install_bytes;
      r_slot_q    <= free_slot_q;
      r_len_q     <= install_bytes ? len_q : '0;
    end
  end

  // In ScanBytes mode the evict decision targets byte victims first; when
  // full after a key scan no byte victim exists, so the any-victim applies.
  always_comb begin
    sts_o              = '0;
    sts_o.scan_last    = cmd_i.scan_step && (addr_q == CountW'(NumSlots - 1));
    sts_o.scan_idle    = !rd_vld_q;
    sts_o.found        = found_q;
    sts_o.have_victim  = vic_q;
    sts_o.have_bvictim = bvic_q;
    sts_o.full         = (count_q == CountW'(NumSlots)) && vic_q;
    sts_o.want_neg     = want_neg;
    sts_o.want_bytes   = install_bytes;
    sts_o.over_budget  = need > {1'b0, budget_q};
  end

  assign rsp_valid           = rsp_valid_q;
  assign rsp_o.hit           = r_hit_q;
  assign rsp_o.present       = r_present_q;
  assign rsp_o.cached        = r_cached_q;
  assign rsp_o.slot          = 9'(r_slot_q);
  assign rsp_o.tile_len      = r_len_q;
  assign rsp_o.hit_count     = hits_q;
  assign rsp_o.miss_count    = misses_q;
  assign rsp_o.bytes_used    = held_q;
  assign rsp_o.entry_count   = 10'(count_q);
endmodule

### rtl/lru_cache_directory_byte_budget.sv
// ----------------------------------------------------------------------------
// lru_cache_directory_byte_budget: LRU tile directory with byte budget
// Fully associative 512-slot directory, LRU eviction by count and bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with req_i while busy is low; the access is then taken.
//   busy stays high until the result strobe done_o, which marks rsp_o for
//   exactly one cycle. The receiver cannot stall; rsp_o must be taken then.
//   byte_budget is written through budget_we_i / budget_wdata_i while idle.
// Timing:
//   Each pass walks all 512 slots through the entry and stamp RAM read port
//   (one slot a cycle, plus a drain). A hit or a plain install shows its
//   result with busy already low in that result cycle, so the next access
//   can follow at once. Every eviction adds one more pass. An install that
//   must evict for bytes, with no entry-limit eviction before it, first
//   spends a pass picking the byte victim.
// Reset:
//   Valid bits, counters and use clock clear at once; budget returns to
//   2 MiB. RAM contents need no clearing since valid bits gate all reads.
// ----------------------------------------------------------------------------
module lru_cache_directory_byte_budget (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  lcd_pkg::req_t            req_i,
  output logic                     done_o,
  output lcd_pkg::rsp_t            rsp_o,
  input  logic                     budget_we_i,
  input  logic [lcd_pkg::LenW-1:0] budget_wdata_i
);
  import lcd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lcd_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .sts_i(sts), .cmd_o(cmd)
  );

  lcd_dpath u_dpath (
    .clk_i, .rst_ni, .req_i,
    .budget_we(budget_we_i), .budget_wdata(budget_wdata_i),
    .cmd_i(cmd), .sts_o(sts), .rsp_valid(done_o), .rsp_o
  );
endmodule

### rtl/lcd_checker.sv
// ----------------------------------------------------------------------------
// lcd_checker: port-level checks of the tile directory
// Result consistency and handshake sanity, bound to the top level.
// ----------------------------------------------------------------------------
module lcd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input lcd_pkg::rsp_t rsp_o
);
  import lcd_pkg::*;

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("access taken but not busy");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without access");
  a_hit_cached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.hit |-> rsp_o.cached) else $error("hit not cached");
  a_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.present |-> rsp_o.cached && rsp_o.tile_len != '0)
    else $error("present without bytes");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.entry_count <= 10'(NumSlots)) else $error("count overflow");
endmodule

bind lru_cache_directory_byte_budget lcd_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .done_o, .rsp_o
);
